// ===== rtl/pslt_pkg.sv =====
// ----------------------------------------------------------------------------
// pslt_pkg: shared types and constants for the source lockout table
// Table geometry, command codes, register indexes, shared unit opcodes, the
// config struct and the structs passed between the sequencer and the table.
// ----------------------------------------------------------------------------
package pslt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PTR_W = IDX_W + 1;

	localparam int KEY_W = 128;
	localparam int NOW_W = 63;
	localparam int END_W = 64;
	localparam int CNT_W = 8;
	localparam int ALU_W = 65;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [19:0] US_PER_SEC = 20'd1000000;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_S = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_S = 2'd2;

	localparam logic [7:0] RST_MAX_FAIL = 8'd5;
	localparam logic [15:0] RST_WINDOW_S = 16'd60;
	localparam logic [15:0] RST_LOCKOUT_S = 16'd300;

	localparam logic [1:0] CMD_CHECK = 2'd0;
	localparam logic [1:0] CMD_FAIL = 2'd1;
	localparam logic [1:0] CMD_SUCCESS = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} alu_op_t;

	typedef struct packed {
		logic [7:0]  max_fail;
		logic [15:0] window_s;
		logic [15:0] lockout_s;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [NOW_W-1:0] first_fail;
		logic [END_W-1:0] lockout_end;
		logic [CNT_W-1:0] fail_count;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic             set;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} tbl_wr_t;

endpackage

// ===== rtl/pslt_if.sv =====
// ----------------------------------------------------------------------------
// pslt_if: channel interfaces of the source lockout table
// Request, response and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pslt_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [63:0]               source_addr_high;
	logic [63:0]               source_addr_low;
	logic [pslt_pkg::NOW_W-1:0] now_us;

	modport source (output valid, command, source_addr_high, source_addr_low, now_us,
		input ready);
	modport sink (input valid, command, source_addr_high, source_addr_low, now_us,
		output ready);
endinterface

interface pslt_rsp_if;
	logic valid;
	logic ready;
	logic locked_out;
	logic lockout_started;
	logic not_recorded;

	modport source (output valid, locked_out, lockout_started, not_recorded, input ready);
	modport sink (input valid, locked_out, lockout_started, not_recorded, output ready);
endinterface

interface pslt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pslt_pkg::CFG_IDX_W-1:0] index;
	logic [pslt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pslt_unit.sv =====
// ----------------------------------------------------------------------------
// pslt_unit: shared arithmetic unit
// 65-bit add/subtract and seconds-to-microseconds multiply, reused by the
// sequencer for every time computation.
// ----------------------------------------------------------------------------
module pslt_unit (
	input  pslt_pkg::alu_op_t              op,
	input  logic [pslt_pkg::ALU_W-1:0]     a,
	input  logic [pslt_pkg::ALU_W-1:0]     b,
	output logic [pslt_pkg::ALU_W-1:0]     y
);

	logic [35:0] prod;

	assign prod = 36'(a[15:0]) * 36'(pslt_pkg::US_PER_SEC);

	always_comb begin
		unique case (op)
			pslt_pkg::OP_ADD: y = a + b;
			pslt_pkg::OP_SUB: y = a - b;
			pslt_pkg::OP_MUL: y = pslt_pkg::ALU_W'(prod);
			default:          y = '0;
		endcase
	end

endmodule

// ===== rtl/pslt_table.sv =====
// ----------------------------------------------------------------------------
// pslt_table: entry storage
// Valid bits in reset flops, entry payload in an array; one registered read
// port and one write port that either writes a full entry or clears valid.
// ----------------------------------------------------------------------------
module pslt_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pslt_pkg::IDX_W-1:0]      rd_addr,
	output logic                            rd_valid,
	output pslt_pkg::entry_t                rd_entry,
	input  pslt_pkg::tbl_wr_t               wr
);

	logic [pslt_pkg::TABLE_ENTRIES-1:0] valid_q;
	pslt_pkg::entry_t mem_q [pslt_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			rd_valid <= valid_q[rd_addr];
			if (wr.en) begin
				valid_q[wr.addr] <= wr.set;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_entry <= mem_q[rd_addr];
		if (wr.en && wr.set) begin
			mem_q[wr.addr] <= wr.entry;
		end
	end

endmodule

// ===== rtl/pslt_seq.sv =====
// ----------------------------------------------------------------------------
// pslt_seq: command sequencer
// Scans the table one entry per cycle; for a failure it then steps the shared
// unit through the window and lockout computations and writes back the entry, while a check or success may erase it.
// ----------------------------------------------------------------------------
module pslt_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pslt_pkg::cfg_t                  cfg,
	pslt_req_if.sink                        req,
	pslt_rsp_if.source                      rsp,
	output logic [pslt_pkg::IDX_W-1:0]      rd_addr,
	input  logic                            rd_valid,
	input  pslt_pkg::entry_t                rd_entry,
	output pslt_pkg::tbl_wr_t               tbl_wr
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHK,
		ST_MULW,
		ST_ADDT,
		ST_WIN,
		ST_LCHK,
		ST_MULL,
		ST_ADDE,
		ST_WRITE,
		ST_RESP
	} state_t;

	localparam logic [pslt_pkg::PTR_W-1:0] PTR_END = pslt_pkg::PTR_W'(pslt_pkg::TABLE_ENTRIES);
	localparam logic [pslt_pkg::IDX_W-1:0] IDX_LAST =
		pslt_pkg::IDX_W'(pslt_pkg::TABLE_ENTRIES - 1);

	state_t                          state_q;
	logic [1:0]                      cmd_q;
	logic [pslt_pkg::KEY_W-1:0]      key_q;
	logic [pslt_pkg::NOW_W-1:0]      now_q;
	logic [pslt_pkg::PTR_W-1:0]      ptr_q;
	logic                            chk_s1;
	logic [pslt_pkg::IDX_W-1:0]      idx_s1;
	logic                            hit_q;
	logic                            free_q;
	logic [pslt_pkg::IDX_W-1:0]      slot_q;
	logic [pslt_pkg::CNT_W-1:0]      cnt_q;
	logic [pslt_pkg::NOW_W-1:0]      first_q;
	logic [pslt_pkg::END_W-1:0]      end_q;
	logic [pslt_pkg::ALU_W-1:0]      acc_q;
	logic                            locked_q;
	logic                            started_q;
	logic                            dropped_q;
	logic                            rsp_valid_q;
	logic                            rsp_locked_q;
	logic                            rsp_started_q;
	logic                            rsp_dropped_q;

	pslt_pkg::alu_op_t               u_op;
	logic [pslt_pkg::ALU_W-1:0]      u_a;
	logic [pslt_pkg::ALU_W-1:0]      u_b;
	logic [pslt_pkg::ALU_W-1:0]      u_y;
	logic                            neg;
	logic                            match;
	logic                            rsp_free;

	pslt_unit u_unit (
		.op (u_op),
		.a  (u_a),
		.b  (u_b),
		.y  (u_y)
	);

	assign neg = u_y[pslt_pkg::ALU_W-1];
	assign match = rd_valid && (rd_entry.key == key_q);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign rd_addr = ptr_q[pslt_pkg::IDX_W-1:0];

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.locked_out = rsp_locked_q;
	assign rsp.lockout_started = rsp_started_q;
	assign rsp.not_recorded = rsp_dropped_q;

	always_comb begin
		u_op = pslt_pkg::OP_ADD;
		u_a = '0;
		u_b = '0;
		unique case (state_q)
			ST_CHK: begin
				u_op = pslt_pkg::OP_SUB;
				u_a = pslt_pkg::ALU_W'(now_q);
				u_b = pslt_pkg::ALU_W'(end_q);
			end
			ST_MULW: begin
				u_op = pslt_pkg::OP_MUL;
				u_a = pslt_pkg::ALU_W'(cfg.window_s);
			end
			ST_ADDT: begin
				u_a = pslt_pkg::ALU_W'(first_q);
				u_b = acc_q;
			end
			ST_WIN: begin
				u_op = pslt_pkg::OP_SUB;
				u_a = acc_q;
				u_b = pslt_pkg::ALU_W'(now_q);
			end
			ST_MULL: begin
				u_op = pslt_pkg::OP_MUL;
				u_a = pslt_pkg::ALU_W'(cfg.lockout_s);
			end
			ST_ADDE: begin
				u_a = pslt_pkg::ALU_W'(now_q);
				u_b = acc_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tbl_wr.en = 1'b0;
		tbl_wr.set = 1'b0;
		tbl_wr.addr = slot_q;
		tbl_wr.entry.key = key_q;
		tbl_wr.entry.first_fail = first_q;
		tbl_wr.entry.lockout_end = end_q;
		tbl_wr.entry.fail_count = cnt_q;
		if (state_q == ST_CHK && hit_q) begin
			// success erases; an expired lockout is erased by a check
			if (cmd_q == pslt_pkg::CMD_SUCCESS ||
				(cmd_q == pslt_pkg::CMD_CHECK && end_q != '0 && !neg)) begin
				tbl_wr.en = 1'b1;
			end
		end else if (state_q == ST_WRITE) begin
			tbl_wr.en = 1'b1;
			tbl_wr.set = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= '0;
			key_q <= '0;
			now_q <= '0;
			ptr_q <= '0;
			chk_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			slot_q <= '0;
			cnt_q <= '0;
			first_q <= '0;
			end_q <= '0;
			acc_q <= '0;
			locked_q <= 1'b0;
			started_q <= 1'b0;
			dropped_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_locked_q <= 1'b0;
			rsp_started_q <= 1'b0;
			rsp_dropped_q <= 1'b0;
		end else begin
			acc_q <= u_y;
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.command;
						key_q <= {req.source_addr_high, req.source_addr_low};
						now_q <= req.now_us;
						ptr_q <= '0;
						chk_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						locked_q <= 1'b0;
						started_q <= 1'b0;
						dropped_q <= 1'b0;
						if (req.command == pslt_pkg::CMD_CHECK ||
							req.command == pslt_pkg::CMD_SUCCESS ||
							(req.command == pslt_pkg::CMD_FAIL && cfg.max_fail != '0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (ptr_q != PTR_END) begin
						ptr_q <= ptr_q + 1'b1;
						idx_s1 <= ptr_q[pslt_pkg::IDX_W-1:0];
					end
					chk_s1 <= (ptr_q != PTR_END) && !(chk_s1 && match);
					if (chk_s1) begin
						if (match) begin
							hit_q <= 1'b1;
							slot_q <= idx_s1;
							cnt_q <= rd_entry.fail_count;
							first_q <= rd_entry.first_fail;
							end_q <= rd_entry.lockout_end;
							state_q <= (cmd_q == pslt_pkg::CMD_FAIL) ? ST_MULW : ST_CHK;
						end else begin
							if (!rd_valid && !free_q) begin
								free_q <= 1'b1;
								slot_q <= idx_s1;
							end
							if (idx_s1 == IDX_LAST) begin
								if (cmd_q != pslt_pkg::CMD_FAIL) begin
									state_q <= ST_CHK;
								end else if (free_q || !rd_valid) begin
									cnt_q <= '0;
									first_q <= '0;
									end_q <= '0;
									state_q <= ST_MULW;
								end else begin
									dropped_q <= 1'b1;
									state_q <= ST_RESP;
								end
							end
						end
					end
				end
				ST_CHK: begin
					if (cmd_q == pslt_pkg::CMD_CHECK && hit_q && end_q != '0 && neg) begin
						locked_q <= 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_MULW: state_q <= ST_ADDT;
				ST_ADDT: state_q <= ST_WIN;
				ST_WIN: begin
					// first + window < now: new window
					if (cnt_q == '0 || neg) begin
						first_q <= now_q;
						cnt_q <= pslt_pkg::CNT_W'(1);
					end else if (cnt_q != pslt_pkg::CNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_LCHK;
				end
				ST_LCHK: begin
					state_q <= (cnt_q >= cfg.max_fail && end_q == '0) ? ST_MULL : ST_WRITE;
				end
				ST_MULL: state_q <= ST_ADDE;
				ST_ADDE: begin
					end_q <= u_y[pslt_pkg::END_W-1:0];
					started_q <= 1'b1;
					state_q <= ST_WRITE;
				end
				ST_WRITE: state_q <= ST_RESP;
				ST_RESP: begin
					if (rsp_free) begin
						rsp_locked_q <= locked_q;
						rsp_started_q <= started_q;
						rsp_dropped_q <= dropped_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous transaction still busy");

	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (state_q == ST_CHK || state_q == ST_WRITE))
		else $error("table write outside check or write-back step");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> $onehot0({rsp_locked_q, rsp_started_q, rsp_dropped_q}))
		else $error("more than one response flag set");

	a_resp_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && rsp_free) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("response not loaded when output register free");

endmodule

// ===== rtl/per_source_auth_lockout_table_top.sv =====
// ----------------------------------------------------------------------------
// per_source_auth_lockout_table_top: per-source authentication lockout table
// Tracks failures per 128-bit source key and reports lockouts.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one transaction per command (check, failure, success) with the
//          source key and the current time in microseconds.
//   rsp  : exactly one transaction per request carrying locked_out,
//          lockout_started and not_recorded; unused flags are zero.
//   cfg  : register writes (max fail count, window, lockout seconds), always
//          ready; write only while no request is in flight.
// Flow: a request scans the table one entry per cycle through the single
//   read port; for a failure the shared add/sub/multiply unit then runs the
//   window and lockout steps. An unknown command or disabled recording
//   skips the scan and answers directly.
// Throughput: one request at a time; req.ready is high only when idle.
// Reset: all entries invalid, registers at 5 / 60 / 300, no response pending.
// Stall: the response sits in an output register; a finished request waits
//   for it to drain before the next request is accepted.
// ----------------------------------------------------------------------------
module per_source_auth_lockout_table_top (
	input  logic        clk,
	input  logic        arst_n,
	pslt_req_if.sink    req,
	pslt_rsp_if.source  rsp,
	pslt_cfg_if.sink    cfg
);

	pslt_pkg::cfg_t                  cfg_q;
	logic [pslt_pkg::IDX_W-1:0]      rd_addr;
	logic                            rd_valid;
	pslt_pkg::entry_t                rd_entry;
	pslt_pkg::tbl_wr_t               tbl_wr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_fail <= pslt_pkg::RST_MAX_FAIL;
			cfg_q.window_s <= pslt_pkg::RST_WINDOW_S;
			cfg_q.lockout_s <= pslt_pkg::RST_LOCKOUT_S;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pslt_pkg::REG_MAX_FAIL:  cfg_q.max_fail <= cfg.data[7:0];
				pslt_pkg::REG_WINDOW_S:  cfg_q.window_s <= cfg.data;
				pslt_pkg::REG_LOCKOUT_S: cfg_q.lockout_s <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	pslt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (req),
		.rsp      (rsp),
		.rd_addr  (rd_addr),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry),
		.tbl_wr   (tbl_wr)
	);

	pslt_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry),
		.wr       (tbl_wr)
	);

endmodule
